// ===== src/nfsa_pkg.sv =====
// Shared constants and types of the next-fit slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package nfsa_pkg;

   // Pool geometry. The used map is held as WORD_COUNT words of WORD_W bits.
   localparam int SLOT_COUNT = 64;
   localparam int IDX_W      = 6;
   localparam int WORD_W     = 8;
   localparam int WORD_COUNT = SLOT_COUNT / WORD_W;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int BIT_AW     = $clog2(WORD_W);
   localparam int SLOT_AW    = WORD_AW + BIT_AW;

   // Request operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] slot_to_free;
   } req_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [WORD_AW-1:0] addr;
      logic [WORD_W-1:0]  data;
   } ram_wr_type;

endpackage

`default_nettype wire

// ===== src/nfsa_bitmap_ram.sv =====
// Used-bit map storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nfsa_bitmap_ram (
   input  logic                         clock,
   input  nfsa_pkg::ram_wr_type         wr,
   input  logic [nfsa_pkg::WORD_AW-1:0] rd_addr,
   output logic [nfsa_pkg::WORD_W-1:0]  rd_data_ff
);
   import nfsa_pkg::*;

   logic [WORD_W-1:0] mem [WORD_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/next_fit_slot_allocator_top.sv =====
// A free passes through the FREE and EMIT states after acceptance; an allocate probes
// 1 to WORD_COUNT + 1 bitmap words in the SCAN state, then passes through EMIT. A new
// item is accepted only in IDLE, once the last result is in the output register. The scan
// reads one 8-bit word of the used map per cycle through the single memory read port.
// Reset: synchronous; all slots read as free and the search pointer is zero at once,
// through per-word valid bits, so an item may be accepted in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module next_fit_slot_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nfsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nfsa_pkg::rsp_type rsp_data
);
   import nfsa_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FREE = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [SLOT_AW-1:0]  ptr_ff, ptr_in;
   logic [WORD_AW-1:0]  scan_word_ff, scan_word_in;
   logic [WORD_AW:0]    scan_cnt_ff, scan_cnt_in;
   logic [SLOT_AW-1:0]  free_slot_ff, free_slot_in;
   logic                free_ok_ff, free_ok_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [WORD_COUNT-1:0] row_valid_ff, row_valid_in;

   ram_wr_type          wr;
   logic [WORD_AW-1:0]  rd_addr;
   logic [WORD_W-1:0]   rd_data_ff;
   logic [WORD_AW-1:0]  cur_word;
   logic [WORD_W-1:0]   cur_data;
   logic [BIT_AW-1:0]   ptr_lo;
   logic [WORD_W-1:0]   probe_mask;
   logic [WORD_W-1:0]   free_bits;
   logic [BIT_AW:0]     hit;
   logic [WORD_AW-1:0]  next_word;
   logic [WORD_W-1:0]   set_data;
   logic [WORD_W-1:0]   clr_data;

   // Lowest set bit of a word, with a found flag on top.
   function automatic logic [BIT_AW:0] first_set(logic [WORD_W-1:0] v);
      logic [BIT_AW:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, BIT_AW'(i)};
         end
      end
      return r;
   endfunction

   nfsa_bitmap_ram u_ram (
      .clock      (clock),
      .wr         (wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ptr_lo   = ptr_ff[BIT_AW-1:0];
   assign cur_word = (state_ff == S_FREE) ? free_slot_ff[SLOT_AW-1:BIT_AW] : scan_word_ff;
   // A word never written since reset holds no used slots.
   assign cur_data = row_valid_ff[cur_word] ? rd_data_ff : '0;

   // The first word is probed from the pointer upward; after a full turn the
   // same word is probed once more below the pointer.
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         if (scan_cnt_ff == '0) begin
            probe_mask[i] = (BIT_AW'(i) >= ptr_lo);
         end else if (scan_cnt_ff == (WORD_AW + 1)'(WORD_COUNT)) begin
            probe_mask[i] = (BIT_AW'(i) < ptr_lo);
         end else begin
            probe_mask[i] = 1'b1;
         end
      end
   end

   assign free_bits = ~cur_data & probe_mask;
   assign hit       = first_set(free_bits);
   assign next_word = (scan_word_ff == WORD_AW'(WORD_COUNT - 1)) ? '0 : scan_word_ff + 1'b1;

   always_comb begin
      set_data = cur_data;
      set_data[hit[BIT_AW-1:0]] = 1'b1;
      clr_data = cur_data;
      clr_data[free_slot_ff[BIT_AW-1:0]] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      scan_word_in = scan_word_ff;
      scan_cnt_in  = scan_cnt_ff;
      free_slot_in = free_slot_ff;
      free_ok_in   = free_ok_ff;
      res_in       = res_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = next_word;
      wr           = '0;

      unique case (state_ff)
         S_IDLE: begin
            free_slot_in = SLOT_AW'(req_data.slot_to_free);
            free_ok_in   = (int'(req_data.slot_to_free) < SLOT_COUNT);
            if (req_data.opcode == OP_FREE) begin
               rd_addr = free_slot_in[SLOT_AW-1:BIT_AW];
            end else begin
               rd_addr = ptr_ff[SLOT_AW-1:BIT_AW];
            end
            if (req_valid) begin
               scan_word_in = ptr_ff[SLOT_AW-1:BIT_AW];
               scan_cnt_in  = '0;
               state_in     = (req_data.opcode == OP_FREE) ? S_FREE : S_SCAN;
            end
         end
         S_FREE: begin
            wr.en   = free_ok_ff;
            wr.addr = cur_word;
            wr.data = clr_data;
            if (free_ok_ff) begin
               row_valid_in[cur_word] = 1'b1;
            end
            res_in   = '0;
            state_in = S_EMIT;
         end
         S_SCAN: begin
            if (hit[BIT_AW]) begin
               wr.en   = 1'b1;
               wr.addr = scan_word_ff;
               wr.data = set_data;
               row_valid_in[scan_word_ff] = 1'b1;
               ptr_in            = {scan_word_ff, hit[BIT_AW-1:0]};
               res_in.granted    = 1'b1;
               res_in.slot_index = IDX_W'({scan_word_ff, hit[BIT_AW-1:0]});
               state_in          = S_EMIT;
            end else if (scan_cnt_ff == (WORD_AW + 1)'(WORD_COUNT)) begin
               // Pool full: the pointer stays where the scan began.
               res_in   = '0;
               state_in = S_EMIT;
            end else begin
               scan_word_in = next_word;
               scan_cnt_in  = scan_cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_word_ff <= scan_word_in;
      scan_cnt_ff  <= scan_cnt_in;
      free_slot_ff <= free_slot_in;
      free_ok_ff   <= free_ok_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== src/nfsa_checker.sv =====
// Port-level checker for the slot allocator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nfsa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input nfsa_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input nfsa_pkg::rsp_type rsp_data
);
   import nfsa_pkg::*;

   // Items accepted whose results have not yet been taken.
   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_acc && !rsp_acc) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |-> rsp_data.slot_index == '0)
      else $error("result without grant carries a nonzero slot index");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("result item shown with no item outstanding");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == 2'd2 |-> !req_ready)
      else $error("new item accepted with two items already outstanding");

endmodule

bind next_fit_slot_allocator_top nfsa_checker u_nfsa_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the next-fit slot allocator with a random driver and a monitor.
`timescale 1ns / 1ps

module tb_top;
   import nfsa_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1050;
   localparam int IDLE_PCT     = 24;
   localparam int CALM_FIRST   = 400;
   localparam int CALM_LAST    = 600;
   localparam int TAIL_CYCLES  = 20;

   typedef enum int {
      PHASE_FILL,
      PHASE_DRAIN,
      PHASE_EVEN
   } phase_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type               item_backlog[$];
   rsp_type               grants_due[$];
   logic [SLOT_COUNT-1:0] pool_busy;
   int                    scan_start;
   int                    items_sent;
   int                    items_seen;
   int                    mismatches;
   int                    cycles;

   next_fit_slot_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type make_item(logic op, int idx);
      req_type r;
      r.opcode       = op;
      r.slot_to_free = idx[IDX_W-1:0];
      return r;
   endfunction

   task automatic add_item(logic op, int idx);
      item_backlog.insert(item_backlog.size(), make_item(op, idx));
   endtask

   // Applies one accepted item to the shadow pool and returns the grant it must produce.
   function automatic rsp_type next_fit_grant(req_type r);
      rsp_type g;
      int      probe;
      int      tries;
      g = '0;
      if (r.opcode == OP_FREE) begin
         if (int'(r.slot_to_free) < SLOT_COUNT) begin
            pool_busy[r.slot_to_free] = 1'b0;
         end
      end else begin
         probe = (scan_start >= SLOT_COUNT) ? 0 : scan_start;
         for (tries = 0; tries < SLOT_COUNT; tries++) begin
            if (!pool_busy[probe]) begin
               break;
            end
            probe = (probe + 1 >= SLOT_COUNT) ? 0 : probe + 1;
         end
         scan_start = probe;
         if (tries < SLOT_COUNT) begin
            pool_busy[probe] = 1'b1;
            g.granted        = 1'b1;
            g.slot_index     = probe[IDX_W-1:0];
         end
      end
      return g;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at result %0d: %s is %0d, expected %0d", items_seen, what, got, want);
      mismatches++;
   endtask

   // Driver: presents queued items and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            grants_due.insert(grants_due.size(), next_fit_grant(req_data));
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (item_backlog.size() != 0 &&
                ((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= item_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each delivered item against the oldest predicted grant.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grants_due.size() == 0) begin
               report("unrequested result", int'(rsp_data), 0);
            end else begin
               want = grants_due.pop_front();
               if (rsp_data.granted !== want.granted) begin
                  report("granted", int'(rsp_data.granted), int'(want.granted));
               end
               if (rsp_data.slot_index !== want.slot_index) begin
                  report("slot_index", int'(rsp_data.slot_index), int'(want.slot_index));
               end
            end
            items_seen++;
         end
         rsp_ready <= (items_seen >= CALM_FIRST && items_seen < CALM_LAST) ||
                      ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      phase_type phase;
      int        run_len;
      int        alloc_pct;
      int        made;
      int        k;
      int        expected_items;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      pool_busy  = '0;
      scan_start = 0;
      items_sent = 0;
      items_seen = 0;
      mismatches = 0;
      cycles     = 0;

      // Frees on an empty pool, first grants, a double free and a stale field on allocate.
      add_item(OP_FREE, 63);
      add_item(OP_FREE, 0);
      add_item(OP_ALLOC, 0);
      add_item(OP_ALLOC, 63);
      add_item(OP_ALLOC, 0);
      add_item(OP_FREE, 1);
      add_item(OP_FREE, 1);
      add_item(OP_ALLOC, 42);
      add_item(OP_FREE, 0);
      add_item(OP_ALLOC, 21);
      add_item(OP_FREE, 2);
      add_item(OP_FREE, 63);
      add_item(OP_ALLOC, 63);
      add_item(OP_ALLOC, 0);

      // Runs that fill the pool past full, drain it, or churn it evenly.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         phase   = phase_type'($urandom_range(2));
         run_len = $urandom_range(20, 100);
         case (phase)
            PHASE_FILL: begin
               alloc_pct = 92;
            end
            PHASE_DRAIN: begin
               alloc_pct = 12;
            end
            default: begin
               alloc_pct = 50;
            end
         endcase
         for (k = 0; k < run_len && made < RANDOM_ITEMS; k++) begin
            add_item(($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE,
                     $urandom_range(SLOT_COUNT - 1));
            made++;
         end
      end
      expected_items = item_backlog.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every item sent must come back before the run is judged.
      while (items_seen < expected_items) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/nfsa_pkg.sv
src/nfsa_bitmap_ram.sv
src/next_fit_slot_allocator_top.sv
src/nfsa_checker.sv
tb/tb_top.sv
